/* hw/rtl/dare_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dare_pkg;

    // Parser phases
    localparam int unsigned PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_HEADER = 4'd0;
    localparam logic [PHASE_W-1:0] PH_QNAME  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_QSKIP  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_QPTR   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_QFIXED = 4'd4;
    localparam logic [PHASE_W-1:0] PH_ANAME  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ASKIP  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_APTR   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_AFIXED = 4'd8;
    localparam logic [PHASE_W-1:0] PH_ARDATA = 4'd9;
    localparam logic [PHASE_W-1:0] PH_DONE   = 4'd10;

    // Status codes
    typedef logic [2:0] status_t;
    localparam status_t ST_FOUND        = 3'd0;
    localparam status_t ST_SHORT        = 3'd1;
    localparam status_t ST_ID_MISMATCH  = 3'd2;
    localparam status_t ST_NOT_RESPONSE = 3'd3;
    localparam status_t ST_NO_ANSWERS   = 3'd4;
    localparam status_t ST_NO_A_RECORD  = 3'd5;

    // Header byte positions
    localparam logic [3:0] HDR_ID_HI   = 4'd0;
    localparam logic [3:0] HDR_ID_LO   = 4'd1;
    localparam logic [3:0] HDR_FLAGS   = 4'd2;
    localparam logic [3:0] HDR_ANC_HI  = 4'd6;
    localparam logic [3:0] HDR_ANC_LO  = 4'd7;
    localparam logic [3:0] HEADER_LEN  = 4'd12;

    // Answer fixed-field positions
    localparam logic [3:0] FLD_TYPE_HI  = 4'd0;
    localparam logic [3:0] FLD_TYPE_LO  = 4'd1;
    localparam logic [3:0] FLD_CLASS_HI = 4'd2;
    localparam logic [3:0] FLD_CLASS_LO = 4'd3;
    localparam logic [3:0] FLD_LEN_HI   = 4'd8;
    localparam logic [3:0] FLD_LEN_LO   = 4'd9;
    localparam logic [3:0] FIXED_LEN    = 4'd10;
    localparam logic [3:0] QFIXED_LEN   = 4'd4;

    // Record constants
    localparam logic [7:0]  PTR_MASK   = 8'hC0;
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] CLASS_IN   = 16'd1;
    localparam logic [15:0] A_RDLENGTH = 16'd4;

endpackage

`default_nettype wire

/* hw/rtl/dns_a_record_extractor_top.sv */
// One result per datagram, valid in the cycle after the marked last byte is accepted.
// Throughput: one payload byte per cycle while not stalled; the state registers update
// on every accepted byte. Input stalls only while a finished result sits in the output
// register and is not taken. Reset (rst_n, asynchronous, active low) returns the parser
// to the header phase, clears expected_id to zero and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module dns_a_record_extractor_top (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write_en,
    input  wire logic [15:0]           cfg_write_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  last_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output dare_pkg::status_t          status,
    output logic [31:0]                address
);
    import dare_pkg::*;

    logic [15:0]        expected_id_reg;

    logic [PHASE_W-1:0] phase_reg,          phase_next;
    logic [3:0]         header_index_reg,   header_index_next;
    logic [7:0]         id_high_byte_reg,   id_high_byte_next;
    logic [2:0]         header_verdict_reg, header_verdict_next;
    logic [15:0]        answers_left_reg,   answers_left_next;
    logic [15:0]        skip_count_reg,     skip_count_next;
    logic [3:0]         field_index_reg,    field_index_next;
    logic [15:0]        record_type_reg,    record_type_next;
    logic [15:0]        record_class_reg,   record_class_next;
    logic [15:0]        record_length_reg,  record_length_next;
    logic [31:0]        address_latch_reg,  address_latch_next;
    logic               found_reg,          found_next;

    logic               out_valid_reg;
    status_t            status_reg,         status_next;
    logic [31:0]        address_reg,        address_next;

    logic               in_fire;
    logic [3:0]         header_index_inc;
    logic [3:0]         field_index_inc;
    logic [15:0]        skip_dec;
    logic [15:0]        answers_dec;
    logic [15:0]        answers_cat;
    logic [15:0]        rlen_now;
    logic               record_is_a;

    // Accept bytes unless a result is stuck in the output register
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Shared arithmetic for the step logic
    assign header_index_inc = header_index_reg + 4'd1;
    assign field_index_inc  = field_index_reg + 4'd1;
    assign skip_dec    = (skip_count_reg != 16'd0) ? skip_count_reg - 16'd1 : skip_count_reg;
    assign answers_dec = (answers_left_reg != 16'd0) ? answers_left_reg - 16'd1
                                                     : answers_left_reg;
    assign answers_cat = {answers_left_reg[15:8], data_byte};
    assign rlen_now    = (field_index_reg == FLD_LEN_LO) ? {record_length_reg[15:8], data_byte}
                                                         : record_length_reg;
    assign record_is_a = (record_type_reg == TYPE_A) && (record_class_reg == CLASS_IN)
                         && (record_length_reg == A_RDLENGTH);

    // Advance the parser by one byte
    always_comb
    begin
        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        id_high_byte_next   = id_high_byte_reg;
        header_verdict_next = header_verdict_reg;
        answers_left_next   = answers_left_reg;
        skip_count_next     = skip_count_reg;
        field_index_next    = field_index_reg;
        record_type_next    = record_type_reg;
        record_class_next   = record_class_reg;
        record_length_next  = record_length_reg;
        address_latch_next  = address_latch_reg;
        found_next          = found_reg;

        unique case (phase_reg)
            PH_HEADER:
            begin
                case (header_index_reg)
                    HDR_ID_HI: id_high_byte_next = data_byte;
                    HDR_ID_LO:
                    begin
                        if ({id_high_byte_reg, data_byte} != expected_id_reg)
                            header_verdict_next = ST_ID_MISMATCH;
                    end
                    HDR_FLAGS:
                    begin
                        if (header_verdict_reg == ST_FOUND && !data_byte[7])
                            header_verdict_next = ST_NOT_RESPONSE;
                    end
                    HDR_ANC_HI: answers_left_next = {data_byte, 8'd0};
                    HDR_ANC_LO:
                    begin
                        answers_left_next = answers_cat;
                        if (header_verdict_reg == ST_FOUND && answers_cat == 16'd0)
                            header_verdict_next = ST_NO_ANSWERS;
                    end
                    default: ;
                endcase
                header_index_next = header_index_inc;
                if (header_index_inc >= HEADER_LEN)
                    phase_next = (header_verdict_next != ST_FOUND) ? PH_DONE : PH_QNAME;
            end
            PH_QNAME, PH_ANAME:
            begin
                if (data_byte == 8'd0)
                begin
                    field_index_next = 4'd0;
                    phase_next = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                end
                else if ((data_byte & PTR_MASK) == PTR_MASK)
                begin
                    phase_next = (phase_reg == PH_QNAME) ? PH_QPTR : PH_APTR;
                end
                else
                begin
                    skip_count_next = {8'd0, data_byte};
                    phase_next = (phase_reg == PH_QNAME) ? PH_QSKIP : PH_ASKIP;
                end
            end
            PH_QSKIP, PH_ASKIP:
            begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0)
                    phase_next = (phase_reg == PH_QSKIP) ? PH_QNAME : PH_ANAME;
            end
            PH_QPTR:
            begin
                field_index_next = 4'd0;
                phase_next       = PH_QFIXED;
            end
            PH_APTR:
            begin
                field_index_next = 4'd0;
                phase_next       = PH_AFIXED;
            end
            PH_QFIXED:
            begin
                field_index_next = field_index_inc;
                if (field_index_inc >= QFIXED_LEN)
                    phase_next = PH_ANAME;
            end
            PH_AFIXED:
            begin
                case (field_index_reg)
                    FLD_TYPE_HI:  record_type_next   = {data_byte, 8'd0};
                    FLD_TYPE_LO:  record_type_next   = {record_type_reg[15:8], data_byte};
                    FLD_CLASS_HI: record_class_next  = {data_byte, 8'd0};
                    FLD_CLASS_LO: record_class_next  = {record_class_reg[15:8], data_byte};
                    FLD_LEN_HI:   record_length_next = {data_byte, 8'd0};
                    FLD_LEN_LO:   record_length_next = rlen_now;
                    default: ;
                endcase
                field_index_next = field_index_inc;
                if (field_index_inc >= FIXED_LEN)
                begin
                    skip_count_next    = rlen_now;
                    address_latch_next = 32'd0;
                    if (rlen_now == 16'd0)
                    begin
                        // Empty rdata: close the record right here
                        answers_left_next = answers_dec;
                        phase_next = (answers_dec == 16'd0) ? PH_DONE : PH_ANAME;
                    end
                    else
                    begin
                        phase_next = PH_ARDATA;
                    end
                end
            end
            PH_ARDATA:
            begin
                address_latch_next = {address_latch_reg[23:0], data_byte};
                skip_count_next    = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    if (record_is_a)
                    begin
                        found_next = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        answers_left_next = answers_dec;
                        phase_next = (answers_dec == 16'd0) ? PH_DONE : PH_ANAME;
                    end
                end
            end
            default: ;
        endcase
    end

    // Form the result from the state after this byte
    always_comb
    begin
        if (header_index_next < HEADER_LEN)
            status_next = ST_SHORT;
        else if (header_verdict_next != ST_FOUND)
            status_next = header_verdict_next;
        else if (found_next)
            status_next = ST_FOUND;
        else
            status_next = ST_NO_A_RECORD;
        address_next = (status_next == ST_FOUND) ? address_latch_next : 32'd0;
    end

    // Hold the configured transaction id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_id_reg <= 16'd0;
        else if (cfg_write_en)
            expected_id_reg <= cfg_write_data;
    end

    // Update parser state; clear it after the last byte of a datagram
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HEADER;
            header_index_reg   <= 4'd0;
            id_high_byte_reg   <= 8'd0;
            header_verdict_reg <= ST_FOUND;
            answers_left_reg   <= 16'd0;
            skip_count_reg     <= 16'd0;
            field_index_reg    <= 4'd0;
            record_type_reg    <= 16'd0;
            record_class_reg   <= 16'd0;
            record_length_reg  <= 16'd0;
            address_latch_reg  <= 32'd0;
            found_reg          <= 1'b0;
        end
        else if (in_fire)
        begin
            if (last_byte)
            begin
                phase_reg          <= PH_HEADER;
                header_index_reg   <= 4'd0;
                id_high_byte_reg   <= 8'd0;
                header_verdict_reg <= ST_FOUND;
                answers_left_reg   <= 16'd0;
                skip_count_reg     <= 16'd0;
                field_index_reg    <= 4'd0;
                record_type_reg    <= 16'd0;
                record_class_reg   <= 16'd0;
                record_length_reg  <= 16'd0;
                address_latch_reg  <= 32'd0;
                found_reg          <= 1'b0;
            end
            else
            begin
                phase_reg          <= phase_next;
                header_index_reg   <= header_index_next;
                id_high_byte_reg   <= id_high_byte_next;
                header_verdict_reg <= header_verdict_next;
                answers_left_reg   <= answers_left_next;
                skip_count_reg     <= skip_count_next;
                field_index_reg    <= field_index_next;
                record_type_reg    <= record_type_next;
                record_class_reg   <= record_class_next;
                record_length_reg  <= record_length_next;
                address_latch_reg  <= address_latch_next;
                found_reg          <= found_next;
            end
        end
    end

    // Output request valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && last_byte)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Load result payload on the last byte
    always_ff @(posedge clk)
    begin
        if (in_fire && last_byte)
        begin
            status_reg  <= status_next;
            address_reg <= address_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign address   = address_reg;

`ifndef NO_ASSERTIONS
    // Address is zero on every result that is not a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_FOUND) |-> (address == 32'd0))
        else $error("nonzero address on a failed result");

    // Leaving the header phase requires the full header
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HEADER) |-> (header_index_reg == HEADER_LEN))
        else $error("header phase left early");

    // A latched record parks the parser
    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (phase_reg == PH_DONE && header_verdict_reg == ST_FOUND))
        else $error("found flag outside done phase");

    // Fixed-field counter stays inside the record header
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_AFIXED) |-> (field_index_reg < FIXED_LEN))
        else $error("fixed-field index overran");
`endif

endmodule

`default_nettype wire
